FILE: rtl/assert_macros.svh
// Assertion macros shared by the peak detector RTL.
// Has no dependencies; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/pdmd_pkg.sv
// Package for the peak detector: configuration codes, widths and shared types.
// No dependencies.
`default_nettype none
package pdmd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int DIST_W     = 16;
  localparam int THRESH_W   = 16;
  localparam logic [DIST_W-1:0] DIST_RESET = 16'd100;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIST   = 8'd0,
    REG_HEIGHT_THR = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic first;
    logic second;
  } pdmd_push_t;

endpackage
`default_nettype wire

FILE: rtl/pdmd_if.sv
// Stream and configuration interfaces of the peak detector.
// Depends on pdmd_pkg for the configuration widths.
`default_nettype none
interface pdmd_in_if #(
  parameter int SW = 16,
  parameter int KW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample;
  logic [KW-1:0]        sample_key;
  logic                 block_end;
  modport source (output valid, sample, sample_key, block_end, input ready);
  modport sink (input valid, sample, sample_key, block_end, output ready);
endinterface

interface pdmd_out_if #(
  parameter int SW = 16,
  parameter int KW = 32
);
  logic                 valid;
  logic                 ready;
  logic [KW-1:0]        peak_key;
  logic signed [SW-1:0] peak_value;
  logic                 peak_valid;
  logic                 last_of_block;
  modport source (output valid, peak_key, peak_value, peak_valid, last_of_block,
                  input ready);
  modport sink (input valid, peak_key, peak_value, peak_valid, last_of_block,
                output ready);
endinterface

interface pdmd_cfg_if import pdmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pdmd_core.sv
// Candidate detection and pending-peak merge for one registered sample.
// Depends on pdmd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pdmd_core import pdmd_pkg::*; #(
  parameter int SW = 16,
  parameter int KW = 32,
  parameter int IW = 32,
  parameter int EW = KW + SW + 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic signed [SW-1:0]       sample_i,
  input  wire logic [KW-1:0]              key_i,
  input  wire logic                       end_i,
  input  wire logic [DIST_W-1:0]          min_dist_i,
  input  wire logic signed [THRESH_W-1:0] thresh_i,
  output pdmd_push_t                      push_o,
  output logic [EW-1:0]                   data0_o,
  output logic [EW-1:0]                   data1_o
);

  localparam int CW = (SW > THRESH_W) ? SW : THRESH_W;

  logic signed [SW-1:0] prev_sample_q;
  logic [KW-1:0]        prev_key_q;
  logic signed [1:0]    prev_sign_q;
  logic [IW-1:0]        seen_q;
  logic                 pend_valid_q;
  logic [IW-1:0]        pend_idx_q;
  logic signed [SW-1:0] pend_val_q;
  logic [KW-1:0]        pend_key_q;

  logic signed [SW:0]   diff;
  logic signed [1:0]    sign_cur;
  logic signed [CW-1:0] prev_ext;
  logic signed [CW-1:0] thr_ext;
  logic                 n_ge1;
  logic                 n_ge2;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        gap;
  logic                 cand;
  logic                 near;
  logic                 take;
  logic                 emit;
  logic                 pend_valid_d;
  logic [IW-1:0]        pend_idx_d;
  logic signed [SW-1:0] pend_val_d;
  logic [KW-1:0]        pend_key_d;
  logic [EW-1:0]        emit_entry;
  logic [EW-1:0]        flush_entry;

  always_comb begin
    diff     = {sample_i[SW-1], sample_i} - {prev_sample_q[SW-1], prev_sample_q};
    sign_cur = diff[SW] ? 2'sb11 : ((|diff) ? 2'sb01 : 2'sb00);
    prev_ext = CW'(prev_sample_q);
    thr_ext  = CW'(thresh_i);
    n_ge1    = |seen_q;
    n_ge2    = |seen_q[IW-1:1];
    idx      = seen_q - 1'b1;
    gap      = idx - pend_idx_q;
    cand     = valid_i && n_ge2 && (sign_cur < prev_sign_q) && (prev_ext > thr_ext);
    near     = pend_valid_q && (gap < IW'(min_dist_i));
    take     = cand && (!near || !(pend_val_q > prev_sample_q));
    emit     = cand && !near && pend_valid_q;

    pend_valid_d = pend_valid_q || cand;
    pend_idx_d   = take ? idx : pend_idx_q;
    pend_val_d   = take ? prev_sample_q : pend_val_q;
    pend_key_d   = take ? prev_key_q : pend_key_q;

    emit_entry = {pend_key_q, pend_val_q, 1'b1, 1'b0};
    if (pend_valid_d) begin
      flush_entry = {pend_key_d, pend_val_d, 1'b1, 1'b1};
    end else begin
      flush_entry = {{(KW + SW + 1){1'b0}}, 1'b1};
    end

    push_o.first  = emit || (valid_i && end_i);
    push_o.second = emit && end_i;
    data0_o       = emit ? emit_entry : flush_entry;
    data1_o       = flush_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sign_q  <= 2'sb00;
      seen_q       <= '0;
      pend_valid_q <= 1'b0;
    end else if (valid_i) begin
      if (end_i) begin
        prev_sign_q  <= 2'sb00;
        seen_q       <= '0;
        pend_valid_q <= 1'b0;
      end else begin
        if (n_ge1) begin
          prev_sign_q <= sign_cur;
        end
        if (seen_q != '1) begin
          seen_q <= seen_q + 1'b1;
        end
        pend_valid_q <= pend_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prev_sample_q <= sample_i;
      prev_key_q    <= key_i;
      pend_idx_q    <= pend_idx_d;
      pend_val_q    <= pend_val_d;
      pend_key_q    <= pend_key_d;
    end
  end

  `ASSERT_NEVER(a_second_needs_first, clk_i, rst_ni, push_o.second && !push_o.first)
  `ASSERT_NEXT(a_end_clears, clk_i, rst_ni, valid_i && end_i, !pend_valid_q && (seen_q == '0))

endmodule
`default_nettype wire

FILE: rtl/pdmd_fifo.sv
// Result queue that takes up to two entries per cycle and gives one while the reader is ready.
// Depends on pdmd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pdmd_fifo import pdmd_pkg::*; #(
  parameter int EW = 50
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pdmd_push_t      push_i,
  input  wire logic [EW-1:0]   data0_i,
  input  wire logic [EW-1:0]   data1_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output logic [EW-1:0]        data_o,
  output logic [FIFO_AW:0]     count_o
);

  logic [EW-1:0]      mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_q;
  logic [FIFO_AW-1:0] tail_q;
  logic [FIFO_AW:0]   count_q;
  logic [FIFO_AW-1:0] tail_next;
  logic [1:0]         wr_cnt;
  logic               pop;

  always_comb begin
    valid_o   = count_q != '0;
    tail_next = tail_q + 1'b1;
    wr_cnt    = {1'b0, push_i.first} + {1'b0, push_i.second};
    pop       = valid_o && ready_i;
    data_o    = mem_q[head_q];
    count_o   = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (pop) begin
        head_q <= head_q + 1'b1;
      end
      tail_q  <= tail_q + FIFO_AW'(wr_cnt);
      count_q <= count_q + (FIFO_AW + 1)'(wr_cnt) - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[tail_q] <= data0_i;
    end
    if (push_i.second) begin
      mem_q[tail_next] <= data1_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni,
                (count_q + (FIFO_AW + 1)'(wr_cnt)) > (FIFO_AW + 1)'(FIFO_DEPTH))
  `ASSERT_NEXT(a_pop_counts_down, clk_i, rst_ni, pop && !push_i.first,
               count_q == $past(count_q) - 1'b1)

endmodule
`default_nettype wire

FILE: rtl/peak_detect_min_distance_top.sv
// Peak detector with minimum distance: an accepted sample is held in the input register, and
// its results are then written into the result queue and taken at the output from there.
// Throughput is one sample per cycle; the input stalls while the 8-entry queue lacks room
// for two results of the staged sample plus two of a new one.
// Asynchronous active-low reset clears block state and queue; distance 100, threshold 0.
// Depends on pdmd_pkg, pdmd_if, pdmd_core and pdmd_fifo.
`default_nettype none
module peak_detect_min_distance_top import pdmd_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int KEY_WIDTH    = 32,
  parameter int INDEX_WIDTH  = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pdmd_in_if.sink     in_i,
  pdmd_out_if.source  out_o,
  pdmd_cfg_if.sink    cfg_i
);

  localparam int EW = KEY_WIDTH + SAMPLE_WIDTH + 2;

  logic [DIST_W-1:0]              min_dist_q;
  logic signed [THRESH_W-1:0]     thresh_q;
  logic                           stage_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] stage_sample_q;
  logic [KEY_WIDTH-1:0]           stage_key_q;
  logic                           stage_end_q;
  pdmd_push_t                     push;
  logic [EW-1:0]                  data0;
  logic [EW-1:0]                  data1;
  logic [EW-1:0]                  head;
  logic [FIFO_AW:0]               fifo_count;
  logic [FIFO_AW+1:0]             reserved;
  logic                           in_fire;

  assign cfg_i.ready = 1'b1;
  assign reserved    = {1'b0, fifo_count} + (stage_valid_q ? (FIFO_AW + 2)'(2) : '0);
  assign in_i.ready  = reserved <= (FIFO_AW + 2)'(FIFO_DEPTH - 2);
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= DIST_RESET;
      thresh_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_MIN_DIST:   min_dist_q <= DIST_W'(cfg_i.data);
        REG_HEIGHT_THR: thresh_q   <= THRESH_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_sample_q <= in_i.sample;
      stage_key_q    <= in_i.sample_key;
      stage_end_q    <= in_i.block_end;
    end
  end

  pdmd_core #(
    .SW(SAMPLE_WIDTH),
    .KW(KEY_WIDTH),
    .IW(INDEX_WIDTH),
    .EW(EW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stage_valid_q),
    .sample_i   (stage_sample_q),
    .key_i      (stage_key_q),
    .end_i      (stage_end_q),
    .min_dist_i (min_dist_q),
    .thresh_i   (thresh_q),
    .push_o     (push),
    .data0_o    (data0),
    .data1_o    (data1)
  );

  pdmd_fifo #(
    .EW(EW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (data0),
    .data1_i (data1),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head),
    .count_o (fifo_count)
  );

  assign out_o.peak_key      = head[EW-1 -: KEY_WIDTH];
  assign out_o.peak_value    = head[SAMPLE_WIDTH+1:2];
  assign out_o.peak_valid    = head[1];
  assign out_o.last_of_block = head[0];

endmodule
`default_nettype wire
